>>> hw/rtl/lat_pkg.sv
`default_nettype none
package lat_pkg;
    localparam int GRID_W = 256;
    localparam int GRID_H = 256;
    localparam int CW = $clog2(GRID_W);
    localparam int RW = $clog2(GRID_H);
    localparam int AW = CW + RW;
    localparam int CELLS = GRID_W * GRID_H;
    localparam int CHG_W = 17;

    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_CHK_RD,
        ST_CHK_EV,
        ST_T_RD,
        ST_T_WR,
        ST_COPY,
        ST_COPY_END,
        ST_RES_RD,
        ST_RES_EV
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/life_automaton_torus_engine.sv
`default_nettype none
// channel  | signals                                  | direction
// command  | start, i_action, i_col, i_row            | in
// result   | o_done, o_alive, o_neighbour_count,      | out
//          | o_changes, busy                          |
// after reset a clearing pass writes both 65536-entry stores, one entry a cycle,
// with busy high throughout. read: result read, then strobe. set/clear: check
// read and evaluate, then a read and a write per neighbour and for the cell if
// it changes. step: scan read and evaluate per cell, that update per changed
// cell (shared read-modify-write port of the next store), then a copy back.
// the result strobe lasts one cycle; the receiver cannot stall it.
module life_automaton_torus_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_col,
    input  wire logic [7:0]  i_row,
    output logic             o_done,
    output logic             o_alive,
    output logic [3:0]       o_neighbour_count,
    output logic [16:0]      o_changes
);
    localparam int CW = lat_pkg::CW;
    localparam int RW = lat_pkg::RW;
    localparam int AW = lat_pkg::AW;
    localparam int CHG_W = lat_pkg::CHG_W;

    logic [4:0] cur_mem [lat_pkg::CELLS];
    logic [4:0] nxt_mem [lat_pkg::CELLS];

    lat_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [3:0]       r_k, n_k;
    logic             r_up, n_up;
    logic             r_step, n_step;
    logic [CW-1:0]    r_c, n_c, r_col, n_col;
    logic [RW-1:0]    r_r, n_r, r_row, n_row;
    logic [CHG_W-1:0] r_changes, n_changes;
    logic             r_cp_v, n_cp_v;
    logic [AW-1:0]    r_cp_a, n_cp_a;

    logic [4:0]    cur_rd, nxt_rd;
    logic [AW-1:0] cur_ra, nxt_ra, cur_wa, nxt_wa;
    logic [4:0]    cur_wd, nxt_wd;
    logic          cur_we, nxt_we;

    logic [CW-1:0] lft, rgt, tc;
    logic [RW-1:0] abv, blw, tr;
    logic [AW-1:0] ta;
    logic [4:0]    tdata;
    logic          born, die, last_cnt, chk_ign;

    assign lft = (r_c == '0) ? CW'(lat_pkg::GRID_W - 1) : r_c - 1'b1;
    assign rgt = (r_c == CW'(lat_pkg::GRID_W - 1)) ? '0 : r_c + 1'b1;
    assign abv = (r_r == '0) ? RW'(lat_pkg::GRID_H - 1) : r_r - 1'b1;
    assign blw = (r_r == RW'(lat_pkg::GRID_H - 1)) ? '0 : r_r + 1'b1;

    always_comb begin
        case (r_k)
            4'd0: begin tc = lft; tr = abv; end
            4'd1: begin tc = r_c; tr = abv; end
            4'd2: begin tc = rgt; tr = abv; end
            4'd3: begin tc = lft; tr = r_r; end
            4'd4: begin tc = rgt; tr = r_r; end
            4'd5: begin tc = lft; tr = blw; end
            4'd6: begin tc = r_c; tr = blw; end
            4'd7: begin tc = rgt; tr = blw; end
            default: begin tc = r_c; tr = r_r; end
        endcase
    end
    assign ta = {tr, tc};

    always_comb begin
        if (r_k == 4'd8) begin
            tdata = {r_up, nxt_rd[3:0]};
        end else if (r_up) begin
            tdata = {nxt_rd[4], nxt_rd[3:0] + 4'd1};
        end else begin
            tdata = {nxt_rd[4], nxt_rd[3:0] - 4'd1};
        end
    end

    assign die = cur_rd[4] && (cur_rd[3:0] != 4'd2) && (cur_rd[3:0] != 4'd3);
    assign born = !cur_rd[4] && (cur_rd[3:0] == 4'd3);
    assign last_cnt = (r_cnt == AW'(lat_pkg::CELLS - 1));
    assign chk_ign = (r_up == nxt_rd[4]);

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            cur_mem[cur_wa] <= cur_wd;
        end
        cur_rd <= cur_mem[cur_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        nxt_rd <= nxt_mem[nxt_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lat_pkg::ST_CLR: begin
                if (last_cnt) n_state = lat_pkg::ST_IDLE;
            end
            lat_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (lat_pkg::t_action'(i_action))
                        lat_pkg::ACT_STEP:                     n_state = lat_pkg::ST_SCAN_RD;
                        lat_pkg::ACT_SET, lat_pkg::ACT_CLEAR:  n_state = lat_pkg::ST_CHK_RD;
                        default:                               n_state = lat_pkg::ST_RES_RD;
                    endcase
                end
            end
            lat_pkg::ST_SCAN_RD: n_state = lat_pkg::ST_SCAN_EV;
            lat_pkg::ST_SCAN_EV: begin
                if (born || die) n_state = lat_pkg::ST_T_RD;
                else if (last_cnt) n_state = lat_pkg::ST_COPY;
                else n_state = lat_pkg::ST_SCAN_RD;
            end
            lat_pkg::ST_CHK_RD: n_state = lat_pkg::ST_CHK_EV;
            lat_pkg::ST_CHK_EV: begin
                n_state = chk_ign ? lat_pkg::ST_RES_RD : lat_pkg::ST_T_RD;
            end
            lat_pkg::ST_T_RD: n_state = lat_pkg::ST_T_WR;
            lat_pkg::ST_T_WR: begin
                if (r_k != 4'd8) n_state = lat_pkg::ST_T_RD;
                else if (!r_step) n_state = lat_pkg::ST_RES_RD;
                else if (last_cnt) n_state = lat_pkg::ST_COPY;
                else n_state = lat_pkg::ST_SCAN_RD;
            end
            lat_pkg::ST_COPY: begin
                if (last_cnt) n_state = lat_pkg::ST_COPY_END;
            end
            lat_pkg::ST_COPY_END: n_state = lat_pkg::ST_RES_RD;
            lat_pkg::ST_RES_RD:   n_state = lat_pkg::ST_RES_EV;
            lat_pkg::ST_RES_EV:   n_state = lat_pkg::ST_IDLE;
            default:              n_state = lat_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt = r_cnt;
        n_k = r_k;
        n_up = r_up;
        n_step = r_step;
        n_c = r_c;
        n_r = r_r;
        n_col = r_col;
        n_row = r_row;
        n_changes = r_changes;
        n_cp_v = 1'b0;
        n_cp_a = r_cnt;
        cur_ra = {r_row, r_col};
        nxt_ra = ta;
        cur_we = 1'b0;
        nxt_we = 1'b0;
        cur_wa = ta;
        nxt_wa = ta;
        cur_wd = tdata;
        nxt_wd = tdata;
        unique case (r_state)
            lat_pkg::ST_CLR: begin
                cur_we = 1'b1;
                nxt_we = 1'b1;
                cur_wa = r_cnt;
                nxt_wa = r_cnt;
                cur_wd = '0;
                nxt_wd = '0;
                n_cnt = r_cnt + 1'b1;
            end
            lat_pkg::ST_IDLE: begin
                n_col = i_col[CW-1:0];
                n_row = i_row[RW-1:0];
                n_c = i_col[CW-1:0];
                n_r = i_row[RW-1:0];
                n_cnt = '0;
                n_k = '0;
                n_changes = '0;
                n_step = (i_action == lat_pkg::ACT_STEP);
                n_up = (i_action == lat_pkg::ACT_SET);
            end
            lat_pkg::ST_SCAN_RD: begin
                cur_ra = r_cnt;
                n_c = r_cnt[CW-1:0];
                n_r = r_cnt[AW-1:CW];
                n_k = '0;
            end
            lat_pkg::ST_SCAN_EV: begin
                n_up = born;
                if (born || die) begin
                    if (r_changes != {CHG_W{1'b1}}) n_changes = r_changes + 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lat_pkg::ST_CHK_RD: begin
                nxt_ra = {r_row, r_col};
            end
            lat_pkg::ST_CHK_EV: begin
                n_k = '0;
            end
            lat_pkg::ST_T_RD: begin
                nxt_ra = ta;
            end
            lat_pkg::ST_T_WR: begin
                nxt_we = 1'b1;
                cur_we = !r_step;
                n_k = r_k + 4'd1;
                if (r_k == 4'd8) n_cnt = r_cnt + 1'b1;
            end
            lat_pkg::ST_COPY: begin
                nxt_ra = r_cnt;
                n_cnt = r_cnt + 1'b1;
                n_cp_v = 1'b1;
                n_cp_a = r_cnt;
            end
            lat_pkg::ST_COPY_END: begin
            end
            lat_pkg::ST_RES_RD: begin
                cur_ra = {r_row, r_col};
            end
            lat_pkg::ST_RES_EV: begin
            end
            default: begin
            end
        endcase
        // copy write lands in the cycle after its read
        if (r_cp_v) begin
            cur_we = 1'b1;
            cur_wa = r_cp_a;
            cur_wd = nxt_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lat_pkg::ST_CLR;
            r_cnt <= '0;
            r_cp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_cp_v <= n_cp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_up <= n_up;
        r_step <= n_step;
        r_c <= n_c;
        r_r <= n_r;
        r_col <= n_col;
        r_row <= n_row;
        r_changes <= n_changes;
        r_cp_a <= n_cp_a;
    end

    assign busy = (r_state != lat_pkg::ST_IDLE);
    assign o_done = (r_state == lat_pkg::ST_RES_EV);
    assign o_alive = cur_rd[4];
    assign o_neighbour_count = cur_rd[3:0];
    assign o_changes = r_changes;
endmodule
`default_nettype wire
